@@ hdl/cihe_pkg.sv @@
// ----------------------------------------------------------------------------
// cihe_pkg
// Types, codes and helper functions shared by the command interface host
// engine modules.
// ----------------------------------------------------------------------------
package cihe_pkg;

  localparam int unsigned REPLY_DEPTH  = 1024;
  localparam int unsigned MAX_COMMAND  = 896;
  localparam int unsigned STATUS_LIMIT = 256;
  localparam int unsigned RC_W         = $clog2(REPLY_DEPTH + 1);
  localparam int unsigned SC_W         = $clog2(STATUS_LIMIT + 2);
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] RESET_TIMEOUT_INIT = 16'd120;

  // Item kinds.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_RESET = 2'd0;
  localparam cmd_t CMD_BYTE  = 2'd1;
  localparam cmd_t CMD_POLL  = 2'd2;

  // Outcome codes.
  typedef logic [2:0] outcome_t;
  localparam outcome_t OC_PENDING  = 3'd0;
  localparam outcome_t OC_DONE     = 3'd1;
  localparam outcome_t OC_TIMEOUT  = 3'd2;
  localparam outcome_t OC_ERROR    = 3'd3;
  localparam outcome_t OC_REJECTED = 3'd4;

  // Device register offsets and control values.
  localparam logic [1:0] REG_CONTROL     = 2'd0;
  localparam logic [1:0] REG_COMMAND     = 2'd1;
  localparam logic [7:0] CTL_ABORT_CLEAR = 8'h0c;
  localparam logic [7:0] CTL_PUSH        = 8'h01;
  localparam logic [7:0] CTL_ACK         = 8'h02;
  localparam logic [7:0] CTL_ABORT       = 8'h04;

  // Status register bit positions.
  localparam int unsigned SB_BUSY   = 0;
  localparam int unsigned SB_ACK    = 1;
  localparam int unsigned SB_ERROR  = 3;
  localparam int unsigned SB_STATUS = 6;
  localparam int unsigned SB_REPLY  = 7;
  localparam logic [1:0]  XFER_LAST = 2'b10;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  ASCII_NINE = 8'h39;
  localparam logic [7:0]  NO_CODE    = 8'hff;

  typedef enum logic [4:0] {
    STAGE_STOPPED   = 5'b00001,
    STAGE_LOADING   = 5'b00010,
    STAGE_RESETTING = 5'b00100,
    STAGE_REPLY     = 5'b01000,
    STAGE_ACK       = 5'b10000
  } stage_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] now_ticks;
    logic [7:0]  device_status;
    logic [7:0]  byte_in;
    logic [9:0]  command_length;
    logic [15:0] timeout_ticks;
  } item_t;

  typedef struct packed {
    logic        bus_write;
    logic [1:0]  bus_reg;
    logic [7:0]  bus_value;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        status_text_valid;
    logic [7:0]  status_text_byte;
    outcome_t    outcome;
    logic [7:0]  status_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t make_result(
    input logic       wr,
    input logic [1:0] bus_reg,
    input logic [7:0] value,
    input logic       rv,
    input logic [7:0] rb,
    input logic       sv,
    input logic [7:0] sb,
    input outcome_t   oc,
    input logic       lst
  );
    result_t r;
    r.bus_write         = wr;
    r.bus_reg           = wr ? bus_reg : 2'd0;
    r.bus_value         = wr ? value : 8'd0;
    r.reply_valid       = rv;
    r.reply_byte        = rv ? rb : 8'd0;
    r.status_text_valid = sv;
    r.status_text_byte  = sv ? sb : 8'd0;
    r.outcome           = oc;
    r.status_code       = NO_CODE;
    r.last              = lst;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // Two leading decimal digits of the status text, or all ones.
  function automatic logic [7:0] status_code_of(
    input logic [SC_W-1:0] count,
    input logic [7:0]      a,
    input logic [7:0]      b
  );
    logic [7:0] da;
    logic [7:0] db;
    da = a - ASCII_ZERO;
    db = b - ASCII_ZERO;
    if (count < SC_W'(2) || !is_digit(a) || !is_digit(b)) begin
      return NO_CODE;
    end
    return 8'((da << 3) + (da << 1) + db);
  endfunction

endpackage

@@ hdl/cihe_engine.sv @@
// ----------------------------------------------------------------------------
// cihe_engine
// Protocol state and the per-item decision logic. One registered item is
// turned combinationally into one or two result items.
// ----------------------------------------------------------------------------
module cihe_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            reset_timeout_we,
  input  logic [15:0]     reset_timeout_wdata,
  input  logic            take,
  input  cihe_pkg::item_t item,
  output cihe_pkg::push_t push
);
  import cihe_pkg::*;

  logic [15:0]     reset_timeout;
  stage_t          stage, stage_next;
  logic [15:0]     start_time, start_time_next;
  logic [15:0]     deadline, deadline_next;
  logic            final_part, final_part_next;
  outcome_t        last_outcome, last_outcome_next;
  logic [9:0]      bytes_left, bytes_left_next;
  logic [RC_W-1:0] reply_count, reply_count_next;
  logic [SC_W-1:0] status_count, status_count_next;
  logic [7:0]      first_char, first_char_next;
  logic [7:0]      second_char, second_char_next;

  logic [7:0]  st;
  logic [15:0] elapsed;
  logic [9:0]  bl;
  logic        rejected;
  logic        fail;
  outcome_t    fail_oc;
  logic        fail_sv;
  result_t     r0, r1;
  logic [1:0]  nres;
  logic [7:0]  code;

  assign st      = item.device_status;
  assign elapsed = item.now_ticks - start_time;

  always_comb begin
    stage_next        = stage;
    start_time_next   = start_time;
    deadline_next     = deadline;
    final_part_next   = final_part;
    last_outcome_next = last_outcome;
    bytes_left_next   = bytes_left;
    reply_count_next  = reply_count;
    status_count_next = status_count;
    first_char_next   = first_char;
    second_char_next  = second_char;
    fail     = 1'b0;
    fail_oc  = OC_ERROR;
    fail_sv  = 1'b0;
    nres     = 2'd1;
    bl       = 10'd0;
    rejected = 1'b0;
    r0 = make_result(1'b0, REG_CONTROL, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b1);
    r1 = r0;

    case (item.cmd)
      CMD_RESET: begin
        stage_next        = STAGE_RESETTING;
        last_outcome_next = OC_PENDING;
        start_time_next   = item.now_ticks;
        deadline_next     = reset_timeout;
        reply_count_next  = '0;
        status_count_next = '0;
        first_char_next   = 8'd0;
        second_char_next  = 8'd0;
        r0 = make_result(st[5:0] != 6'd0, REG_CONTROL, CTL_ABORT_CLEAR,
                         1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b1);
      end
      CMD_BYTE: begin
        if (stage == STAGE_STOPPED) begin
          rejected = (item.command_length == 10'd0) ||
                     (item.command_length > 10'(MAX_COMMAND)) ||
                     (st[5:0] != 6'd0);
        end else begin
          rejected = (stage != STAGE_LOADING);
        end
        if (rejected) begin
          r0.outcome = OC_REJECTED;
        end else begin
          bl = bytes_left;
          if (stage == STAGE_STOPPED) begin
            // A new command starts: the length and deadline are taken here.
            reply_count_next  = '0;
            status_count_next = '0;
            first_char_next   = 8'd0;
            second_char_next  = 8'd0;
            last_outcome_next = OC_PENDING;
            deadline_next     = item.timeout_ticks;
            bl                = item.command_length;
          end
          if (bl != 10'd0) begin
            bl = bl - 10'd1;
          end
          bytes_left_next = bl;
          if (bl != 10'd0) begin
            stage_next = STAGE_LOADING;
            r0 = make_result(1'b1, REG_COMMAND, item.byte_in, 1'b0, 8'd0, 1'b0, 8'd0,
                             OC_PENDING, 1'b1);
          end else begin
            stage_next      = STAGE_REPLY;
            start_time_next = item.now_ticks;
            nres            = 2'd2;
            r0 = make_result(1'b1, REG_COMMAND, item.byte_in, 1'b0, 8'd0, 1'b0, 8'd0,
                             OC_PENDING, 1'b0);
            r1 = make_result(1'b1, REG_CONTROL, CTL_PUSH, 1'b0, 8'd0, 1'b0, 8'd0,
                             OC_PENDING, 1'b1);
          end
        end
      end
      default: begin
        if (item.cmd != CMD_POLL || stage == STAGE_STOPPED || stage == STAGE_LOADING) begin
          r0.outcome = (stage == STAGE_LOADING) ? OC_PENDING : last_outcome;
        end else if (elapsed >= deadline) begin
          fail    = 1'b1;
          fail_oc = OC_TIMEOUT;
        end else if (stage == STAGE_RESETTING) begin
          if (st[5:0] == 6'd0) begin
            stage_next        = STAGE_STOPPED;
            last_outcome_next = OC_DONE;
          end
          r0.outcome = last_outcome_next;
        end else if (st[SB_ERROR]) begin
          fail = 1'b1;
        end else if (stage == STAGE_ACK && st[SB_ACK]) begin
          r0.outcome = OC_PENDING;
        end else if (stage == STAGE_ACK && final_part) begin
          if (st[SB_BUSY] == 1'b0 && st[5:4] == 2'b00) begin
            stage_next        = STAGE_STOPPED;
            last_outcome_next = OC_DONE;
          end
          r0.outcome = last_outcome_next;
        end else begin
          // Reply stage, or an acknowledge that has been taken by the device.
          stage_next = STAGE_REPLY;
          if (st[SB_BUSY] || st[5:4] < XFER_LAST) begin
            r0.outcome = OC_PENDING;
          end else begin
            final_part_next = (st[5:4] == XFER_LAST);
            if (st[SB_REPLY]) begin
              if (reply_count >= RC_W'(REPLY_DEPTH)) begin
                fail = 1'b1;
              end else begin
                reply_count_next = reply_count + RC_W'(1);
                r0 = make_result(1'b0, REG_CONTROL, 8'd0, 1'b1, item.byte_in, 1'b0, 8'd0,
                                 OC_PENDING, 1'b1);
              end
            end else if (st[SB_STATUS]) begin
              if (status_count == SC_W'(0)) begin
                first_char_next = item.byte_in;
              end
              if (status_count == SC_W'(1)) begin
                second_char_next = item.byte_in;
              end
              status_count_next = status_count + SC_W'(1);
              if (status_count_next > SC_W'(STATUS_LIMIT)) begin
                fail    = 1'b1;
                fail_sv = 1'b1;
              end else begin
                r0 = make_result(1'b0, REG_CONTROL, 8'd0, 1'b0, 8'd0, 1'b1, item.byte_in,
                                 OC_PENDING, 1'b1);
              end
            end else begin
              stage_next = STAGE_ACK;
              r0 = make_result(1'b1, REG_CONTROL, CTL_ACK, 1'b0, 8'd0, 1'b0, 8'd0,
                               OC_PENDING, 1'b1);
            end
          end
        end
      end
    endcase

    if (fail) begin
      stage_next        = STAGE_STOPPED;
      last_outcome_next = fail_oc;
      r0 = make_result(1'b1, REG_CONTROL, CTL_ABORT, 1'b0, 8'd0, fail_sv, item.byte_in,
                       fail_oc, 1'b1);
    end
  end

  // The status code reflects the capture state after this item.
  assign code = status_code_of(status_count_next, first_char_next, second_char_next);

  always_comb begin
    push        = '0;
    push.count  = take ? nres : 2'd0;
    push.first  = r0;
    push.second = r1;
    push.first.status_code  = code;
    push.second.status_code = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_timeout <= RESET_TIMEOUT_INIT;
    end else if (reset_timeout_we) begin
      reset_timeout <= reset_timeout_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= STAGE_STOPPED;
      start_time   <= 16'd0;
      deadline     <= 16'd0;
      final_part   <= 1'b0;
      last_outcome <= OC_DONE;
      bytes_left   <= 10'd0;
      reply_count  <= '0;
      status_count <= '0;
      first_char   <= 8'd0;
      second_char  <= 8'd0;
    end else if (take) begin
      stage        <= stage_next;
      start_time   <= start_time_next;
      deadline     <= deadline_next;
      final_part   <= final_part_next;
      last_outcome <= last_outcome_next;
      bytes_left   <= bytes_left_next;
      reply_count  <= reply_count_next;
      status_count <= status_count_next;
      first_char   <= first_char_next;
      second_char  <= second_char_next;
    end
  end

endmodule

@@ hdl/cihe_out_queue.sv @@
// ----------------------------------------------------------------------------
// cihe_out_queue
// Small result queue. Takes up to two result items per cycle from the engine
// and hands one item per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module cihe_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  cihe_pkg::push_t               push,
  input  logic                          out_ready,
  output logic                          out_valid,
  output cihe_pkg::result_t             head,
  output logic [cihe_pkg::QCNT_W-1:0]   count
);
  import cihe_pkg::*;

  result_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count_next;
  logic               pop;

  assign out_valid  = (count != '0);
  assign head       = slots[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

@@ hdl/command_interface_host_engine_core.sv @@
// ----------------------------------------------------------------------------
// command_interface_host_engine_core
// Host-side engine for a register-based command interface.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries reset, command-byte and poll
// items, each with a status register snapshot and a tick count. The output
// channel (out_valid/out_ready) carries result items: register writes,
// captured reply and status bytes, the outcome and the status code. An item
// yields one result, or two for the final command byte; last marks the final
// one. reset_timeout is written through reset_timeout_we/reset_timeout_wdata;
// the user must write it only while the block is idle; this is not enforced.
// An accepted item is held in the input register; its results are written to
// the result queue and offered from there. One item per cycle is accepted as
// long as the four-entry result queue has room for two results, so items
// with a single result stream at one per cycle and the output port sets the
// rate for two-result items. When the receiver stalls, the queue fills and
// in_ready drops. Reset empties the queue and input register, sets the
// engine to stopped with outcome done and reset_timeout to 120.
// ----------------------------------------------------------------------------
module command_interface_host_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        reset_timeout_we,
  input  logic [15:0] reset_timeout_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] now_ticks,
  input  logic [7:0]  device_status,
  input  logic [7:0]  byte_in,
  input  logic [9:0]  command_length,
  input  logic [15:0] timeout_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        bus_write,
  output logic [1:0]  bus_reg,
  output logic [7:0]  bus_value,
  output logic        reply_valid,
  output logic [7:0]  reply_byte,
  output logic        status_text_valid,
  output logic [7:0]  status_text_byte,
  output logic [2:0]  outcome,
  output logic [7:0]  status_code,
  output logic        last
);
  import cihe_pkg::*;

  item_t             item;
  logic              item_valid;
  logic              take;
  push_t             push;
  result_t           head;
  logic [QCNT_W-1:0] q_count;

  // The held item is processed once the queue has room for two results.
  assign take     = item_valid && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cmd            <= cmd;
      item.now_ticks      <= now_ticks;
      item.device_status  <= device_status;
      item.byte_in        <= byte_in;
      item.command_length <= command_length;
      item.timeout_ticks  <= timeout_ticks;
    end
  end

  cihe_engine u_engine (
    .clk                 (clk),
    .rst                 (rst),
    .reset_timeout_we    (reset_timeout_we),
    .reset_timeout_wdata (reset_timeout_wdata),
    .take                (take),
    .item                (item),
    .push                (push)
  );

  cihe_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign bus_write         = head.bus_write;
  assign bus_reg           = head.bus_reg;
  assign bus_value         = head.bus_value;
  assign reply_valid       = head.reply_valid;
  assign reply_byte        = head.reply_byte;
  assign status_text_valid = head.status_text_valid;
  assign status_text_byte  = head.status_text_byte;
  assign outcome           = head.outcome;
  assign status_code       = head.status_code;
  assign last              = head.last;

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A result without a register write carries a cleared offset and value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !bus_write) |-> (bus_reg == 2'd0 && bus_value == 8'd0))
    else $error("stale register write fields");

  // The second result of an item is already queued behind the first.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("result item missing after non-final result");

  // Nothing is offered right after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

@@ tb/tb_command_interface_host_engine_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_interface_host_engine_core
// Self-checking testbench for the command interface host engine. A driver
// offers reset, command-byte and poll items from a queue, and a monitor
// compares every result item with the output of a predictor that tracks
// the engine stage, deadlines and captured bytes. Both sides idle at random,
// the receiver stalls once for a long stretch, and reset_timeout is changed
// between phases.
// ----------------------------------------------------------------------------
module tb_command_interface_host_engine_core;
  import cihe_pkg::*;

  localparam cmd_t       CMD_OTHER  = 2'd3;
  localparam logic [7:0] LOW_BITS   = 8'h3f;
  localparam logic [7:0] XFER_MASK  = 8'h30;
  localparam logic [7:0] XFER_MORE  = 8'h30;
  localparam logic [7:0] XFER_FINAL = 8'h20;
  localparam logic [7:0] BUSY_BIT   = 8'h01;
  localparam logic [7:0] ACK_BIT    = 8'h02;
  localparam logic [7:0] ERR_BIT    = 8'h08;
  localparam logic [7:0] STATUS_BIT = 8'h40;
  localparam logic [7:0] REPLY_BIT  = 8'h80;
  localparam logic [7:0] DONE_MASK  = 8'h31;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_FROM      = 1000;
  localparam int CALM_TO        = 1300;
  localparam int IDLE_PCT       = 34;
  localparam int MAX_SHOWN      = 10;
  localparam int PHASE_ITEMS    = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  item_t       offer = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        bus_write;
  logic [1:0]  bus_reg;
  logic [7:0]  bus_value;
  logic        reply_valid;
  logic [7:0]  reply_byte;
  logic        status_text_valid;
  logic [7:0]  status_text_byte;
  logic [2:0]  outcome;
  logic [7:0]  status_code;
  logic        last;
  result_t     seen;
  result_t     want_r;

  item_t   stim_q[$];
  result_t host_results_q[$];

  // Copy of the engine state kept by the predictor.
  stage_t      eng_stage;
  logic [15:0] eng_start;
  logic [15:0] eng_deadline;
  logic [15:0] eng_rst_tmo;
  logic        eng_final;
  outcome_t    eng_last;
  logic [9:0]  eng_left;
  int unsigned eng_replies;
  int unsigned eng_status_n;
  logic [7:0]  eng_char0;
  logic [7:0]  eng_char1;

  logic [15:0] tick;
  bit          seq_broken;
  bit          sent;
  bit          hold_done;
  int          hold_left;
  int          stall_n;
  int          n_queued;
  int          n_in_acc;
  int          n_bad;
  int          n_results;
  int          n_writes;
  int          n_replies;
  int          n_status;
  int          n_timeouts;
  int          n_errors;
  int          n_rejected;
  int          n_settings;

  command_interface_host_engine_core u_top (
    .clk                 (clk),
    .rst                 (rst),
    .reset_timeout_we    (cfg_we),
    .reset_timeout_wdata (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .cmd                 (offer.cmd),
    .now_ticks           (offer.now_ticks),
    .device_status       (offer.device_status),
    .byte_in             (offer.byte_in),
    .command_length      (offer.command_length),
    .timeout_ticks       (offer.timeout_ticks),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .bus_write           (bus_write),
    .bus_reg             (bus_reg),
    .bus_value           (bus_value),
    .reply_valid         (reply_valid),
    .reply_byte          (reply_byte),
    .status_text_valid   (status_text_valid),
    .status_text_byte    (status_text_byte),
    .outcome             (outcome),
    .status_code         (status_code),
    .last                (last)
  );

  assign seen = {bus_write, bus_reg, bus_value, reply_valid, reply_byte,
                 status_text_valid, status_text_byte, outcome, status_code, last};

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] text_code();
    if (eng_status_n < 2 || eng_char0 < 8'h30 || eng_char0 > 8'h39 ||
        eng_char1 < 8'h30 || eng_char1 > 8'h39) begin
      return NO_CODE;
    end
    return 8'((int'(eng_char0) - 48) * 10 + (int'(eng_char1) - 48));
  endfunction

  function automatic void clear_text();
    eng_replies  = 0;
    eng_status_n = 0;
    eng_char0    = 8'd0;
    eng_char1    = 8'd0;
  endfunction

  function automatic void emit(logic wr, logic [1:0] rg, logic [7:0] val,
                               logic rv, logic [7:0] rb, logic sv, logic [7:0] sb,
                               outcome_t oc, logic lst);
    result_t r;
    r.bus_write         = wr;
    r.bus_reg           = wr ? rg : 2'd0;
    r.bus_value         = wr ? val : 8'd0;
    r.reply_valid       = rv;
    r.reply_byte        = rv ? rb : 8'd0;
    r.status_text_valid = sv;
    r.status_text_byte  = sv ? sb : 8'd0;
    r.outcome           = oc;
    r.status_code       = text_code();
    r.last              = lst;
    host_results_q.push_back(r);
    n_results++;
    n_writes   += wr;
    n_replies  += rv;
    n_status   += sv;
    n_timeouts += (oc == OC_TIMEOUT);
    n_errors   += (oc == OC_ERROR);
    n_rejected += (oc == OC_REJECTED);
  endfunction

  function automatic void plain(outcome_t oc);
    emit(1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, oc, 1'b1);
  endfunction

  function automatic void abort_stop(outcome_t oc, logic sv, logic [7:0] sb);
    eng_stage = STAGE_STOPPED;
    eng_last  = oc;
    emit(1'b1, REG_CONTROL, CTL_ABORT, 1'b0, 8'd0, sv, sb, oc, 1'b1);
  endfunction

  function automatic void host_engine_step(item_t it);
    logic [7:0]  st;
    logic [15:0] elapsed;
    st = it.device_status;

    if (it.cmd == CMD_RESET) begin
      eng_stage    = STAGE_RESETTING;
      eng_last     = OC_PENDING;
      eng_start    = it.now_ticks;
      eng_deadline = eng_rst_tmo;
      clear_text();
      emit((st & LOW_BITS) != 0, REG_CONTROL, CTL_ABORT_CLEAR, 1'b0, 8'd0, 1'b0, 8'd0,
           OC_PENDING, 1'b1);
      return;
    end

    if (it.cmd == CMD_BYTE) begin
      if (eng_stage == STAGE_STOPPED) begin
        if (it.command_length == 0 || it.command_length > MAX_COMMAND ||
            (st & LOW_BITS) != 0) begin
          plain(OC_REJECTED);
          return;
        end
        clear_text();
        eng_last     = OC_PENDING;
        eng_deadline = it.timeout_ticks;
        eng_left     = it.command_length;
        eng_stage    = STAGE_LOADING;
      end else if (eng_stage != STAGE_LOADING) begin
        plain(OC_REJECTED);
        return;
      end
      if (eng_left != 0) eng_left--;
      if (eng_left != 0) begin
        emit(1'b1, REG_COMMAND, it.byte_in, 1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b1);
        return;
      end
      // The final byte is followed by the push in a second result.
      eng_stage = STAGE_REPLY;
      eng_start = it.now_ticks;
      emit(1'b1, REG_COMMAND, it.byte_in, 1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b0);
      emit(1'b1, REG_CONTROL, CTL_PUSH, 1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b1);
      return;
    end

    if (it.cmd == CMD_OTHER || eng_stage == STAGE_STOPPED || eng_stage == STAGE_LOADING) begin
      plain((eng_stage == STAGE_LOADING) ? OC_PENDING : eng_last);
      return;
    end

    elapsed = it.now_ticks - eng_start;
    if (elapsed >= eng_deadline) begin
      abort_stop(OC_TIMEOUT, 1'b0, 8'd0);
      return;
    end

    if (eng_stage == STAGE_RESETTING) begin
      if ((st & LOW_BITS) == 0) begin
        eng_stage = STAGE_STOPPED;
        eng_last  = OC_DONE;
      end
      plain(eng_last);
      return;
    end

    if ((st & ERR_BIT) != 0) begin
      abort_stop(OC_ERROR, 1'b0, 8'd0);
      return;
    end

    if (eng_stage == STAGE_ACK) begin
      if ((st & ACK_BIT) != 0) begin
        plain(OC_PENDING);
        return;
      end
      if (eng_final) begin
        if ((st & DONE_MASK) == 0) begin
          eng_stage = STAGE_STOPPED;
          eng_last  = OC_DONE;
        end
        plain(eng_last);
        return;
      end
      // Acknowledge cleared on a middle part: this poll starts the next part.
      eng_stage = STAGE_REPLY;
    end

    if ((st & BUSY_BIT) != 0 || (st & XFER_MASK) < XFER_FINAL) begin
      plain(OC_PENDING);
      return;
    end
    eng_final = ((st & XFER_MASK) == XFER_FINAL);

    if ((st & REPLY_BIT) != 0) begin
      if (eng_replies >= REPLY_DEPTH) begin
        abort_stop(OC_ERROR, 1'b0, 8'd0);
        return;
      end
      eng_replies++;
      emit(1'b0, 2'd0, 8'd0, 1'b1, it.byte_in, 1'b0, 8'd0, OC_PENDING, 1'b1);
      return;
    end

    if ((st & STATUS_BIT) != 0) begin
      if (eng_status_n == 0) eng_char0 = it.byte_in;
      if (eng_status_n == 1) eng_char1 = it.byte_in;
      eng_status_n++;
      if (eng_status_n > STATUS_LIMIT) begin
        abort_stop(OC_ERROR, 1'b1, it.byte_in);
        return;
      end
      emit(1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b1, it.byte_in, OC_PENDING, 1'b1);
      return;
    end

    eng_stage = STAGE_ACK;
    emit(1'b1, REG_CONTROL, CTL_ACK, 1'b0, 8'd0, 1'b0, 8'd0, OC_PENDING, 1'b1);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_item(cmd_t c, logic [7:0] st, logic [7:0] b,
                                   logic [9:0] len, logic [15:0] tmo);
    item_t it;
    it.cmd            = c;
    it.now_ticks      = tick;
    it.device_status  = st;
    it.byte_in        = b;
    it.command_length = len;
    it.timeout_ticks  = tmo;
    stim_q.push_back(it);
    n_queued++;
    tick = tick + 16'($urandom_range(0, 5));
  endfunction

  // Poll with an occasional error bit, which ends the sequence early.
  function automatic void poll(logic [7:0] st, logic [7:0] b);
    if ($urandom_range(0, 99) < 2) begin
      st = st | ERR_BIT;
      seq_broken = 1'b1;
    end
    add_item(CMD_POLL, st, b, 10'($urandom), 16'($urandom));
  endfunction

  function automatic logic [7:0] busy_status();
    logic [7:0] hi;
    hi = 8'($urandom) & 8'hc4;
    if ($urandom_range(0, 1) == 1) return hi | BUSY_BIT | (8'($urandom) & XFER_MASK);
    return hi | (8'($urandom) & 8'h10);
  endfunction

  function automatic void gen_command();
    int          p;
    int          len;
    int          parts;
    int          k;
    logic [7:0]  xfer;
    logic [7:0]  st;
    logic [7:0]  b;
    logic [15:0] tmo;
    seq_broken = 1'b0;
    p = $urandom_range(0, 99);
    if (p < 88) begin
      len = $urandom_range(1, 5);
    end else if (p < 96) begin
      len = $urandom_range(6, 40);
    end else begin
      len = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(MAX_COMMAND + 1, 1023);
      add_item(CMD_BYTE, 8'($urandom) & 8'hc0, 8'($urandom), 10'(len), 16'($urandom));
      return;
    end
    tmo = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(400, 65535))
                                       : 16'($urandom_range(0, 60));
    st = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(1, 255)) : (8'($urandom) & 8'hc0);
    add_item(CMD_BYTE, st, 8'($urandom), 10'(len), tmo);
    for (k = 1; k < len; k++) begin
      if ($urandom_range(0, 99) < 10) add_item(CMD_POLL, 8'($urandom), 8'($urandom), 0, 0);
      add_item(CMD_BYTE, 8'($urandom), 8'($urandom), 10'($urandom), 16'($urandom));
    end
    parts = $urandom_range(1, 3);
    for (int pt = 0; pt < parts && !seq_broken; pt++) begin
      xfer = (pt == parts - 1) ? XFER_FINAL : XFER_MORE;
      repeat ($urandom_range(0, 2)) poll(busy_status(), 8'($urandom));
      repeat ($urandom_range(0, 4)) poll(REPLY_BIT | xfer | (8'($urandom) & 8'h44), 8'($urandom));
      k = 0;
      repeat ($urandom_range(0, 4)) begin
        b = (k < 2 && $urandom_range(0, 99) < 70) ? 8'(8'h30 + $urandom_range(0, 9))
                                                  : 8'($urandom);
        poll(STATUS_BIT | xfer | (8'($urandom) & 8'h04), b);
        k++;
      end
      poll(xfer | (8'($urandom) & 8'h04), 8'($urandom));
      repeat ($urandom_range(0, 2)) poll(ACK_BIT | (8'($urandom) & 8'hf4), 8'($urandom));
      if (pt == parts - 1) begin
        repeat ($urandom_range(0, 1)) poll(BUSY_BIT | (8'($urandom) & XFER_MASK), 8'($urandom));
        poll(8'($urandom) & 8'hc4, 8'($urandom));
      end
    end
  endfunction

  function automatic void gen_reset();
    logic [7:0] st;
    st = ($urandom_range(0, 1) == 1) ? (8'($urandom) & 8'hc0) : 8'($urandom);
    add_item(CMD_RESET, st, 8'($urandom), 10'($urandom), 16'($urandom));
    repeat ($urandom_range(0, 3)) begin
      add_item(CMD_POLL, (8'($urandom) & 8'hfe) | BUSY_BIT, 8'($urandom), 10'($urandom),
               16'($urandom));
    end
    add_item(CMD_POLL, 8'($urandom) & 8'hc0, 8'($urandom), 10'($urandom), 16'($urandom));
  endfunction

  function automatic void gen_random(int n);
    int target;
    int r;
    target = n_queued + n;
    while (n_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        gen_command();
      end else if (r < 75) begin
        gen_reset();
      end else if (r < 92) begin
        add_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 10'($urandom),
                 16'($urandom));
      end else begin
        tick = tick + 16'($urandom);
        add_item(CMD_POLL, 8'($urandom), 8'($urandom), 10'($urandom), 16'($urandom));
      end
    end
  endfunction

  // One-byte commands whose reply and status captures run past their limits.
  function automatic void gen_overflow();
    add_item(CMD_RESET, 8'h00, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_BYTE, 8'h00, 8'($urandom), 10'd1, 16'hffff);
    repeat (REPLY_DEPTH + 1) add_item(CMD_POLL, REPLY_BIT | XFER_MORE, 8'($urandom), 0, 0);
    add_item(CMD_BYTE, 8'h00, 8'($urandom), 10'd1, 16'hffff);
    add_item(CMD_POLL, STATUS_BIT | XFER_MORE, 8'h39, 0, 0);
    add_item(CMD_POLL, STATUS_BIT | XFER_MORE, 8'h30, 0, 0);
    repeat (STATUS_LIMIT - 1) add_item(CMD_POLL, STATUS_BIT | XFER_MORE, 8'($urandom), 0, 0);
  endfunction

  function automatic bit side_idles();
    if (n_in_acc >= CALM_FROM && n_in_acc < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic wait_idle();
    while (stim_q.size() != 0 || in_valid || host_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(negedge clk);
    cfg_we      = 1'b1;
    cfg_data    = v;
    eng_rst_tmo = v;
    n_settings++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sent) begin
      sent = 1'b0;
      if (stim_q.size() != 0 && !side_idles()) begin
        offer    <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      host_engine_step(offer);
      sent = 1'b1;
      n_in_acc++;
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && n_in_acc >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !side_idles();
      end
    end
  end

  function automatic string show(result_t r);
    return $sformatf("wr=%0d reg=%0d val=%02h rv=%0d rb=%02h sv=%0d sb=%02h oc=%0d code=%0d last=%0d",
                     r.bus_write, r.bus_reg, r.bus_value, r.reply_valid, r.reply_byte,
                     r.status_text_valid, r.status_text_byte, r.outcome, r.status_code, r.last);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (host_results_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN) $display("Unexpected result item: %s", show(seen));
      end else begin
        want_r = host_results_q.pop_front();
        if (seen !== want_r) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN) begin
            $display("Mismatch at %0t: expected %s", $realtime, show(want_r));
            $display("                 actual   %s", show(seen));
          end
        end
      end
    end
  end

  // The watchdog only runs while work is outstanding.
  always @(posedge clk) begin
    if (rst || !(stim_q.size() != 0 || in_valid || host_results_q.size() != 0)) begin
      stall_n = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_n = 0;
    end else begin
      stall_n++;
      if (stall_n >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    eng_stage    = STAGE_STOPPED;
    eng_start    = 16'd0;
    eng_deadline = 16'd0;
    eng_rst_tmo  = RESET_TIMEOUT_INIT;
    eng_final    = 1'b0;
    eng_last     = OC_DONE;
    eng_left     = 10'd0;
    clear_text();
    tick = 16'hfff0;

    // Directed opening; the tick count wraps partway through.
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_OTHER, 8'hff, 8'hff, 10'h3ff, 16'hffff);
    add_item(CMD_BYTE, 8'h00, 8'haa, 10'd0, 16'd100);
    add_item(CMD_BYTE, 8'h00, 8'h55, 10'(MAX_COMMAND + 1), 16'd100);
    add_item(CMD_BYTE, 8'h01, 8'h00, 10'd1, 16'd100);
    add_item(CMD_BYTE, 8'hc0, 8'hff, 10'd1, 16'd0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_RESET, 8'h3f, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h01, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_RESET, 8'h00, 8'h00, 0, 0);
    tick = tick + 16'd200;
    add_item(CMD_POLL, 8'h01, 8'h00, 0, 0);
    add_item(CMD_BYTE, 8'h00, 8'h00, 10'd3, 16'hffff);
    add_item(CMD_POLL, 8'hff, 8'h00, 0, 0);
    add_item(CMD_BYTE, 8'h3f, 8'h12, 10'h3ff, 16'h0000);
    add_item(CMD_BYTE, 8'h00, 8'hff, 10'd0, 16'h0000);
    add_item(CMD_BYTE, 8'h00, 8'h77, 10'd1, 16'd10);
    add_item(CMD_POLL, REPLY_BIT | XFER_MORE, 8'hab, 0, 0);
    add_item(CMD_POLL, STATUS_BIT | XFER_MORE, 8'h34, 0, 0);
    add_item(CMD_POLL, STATUS_BIT | XFER_MORE, 8'h32, 0, 0);
    add_item(CMD_POLL, XFER_MORE, 8'h00, 0, 0);
    add_item(CMD_POLL, ACK_BIT, 8'h00, 0, 0);
    add_item(CMD_POLL, REPLY_BIT | XFER_FINAL, 8'h5a, 0, 0);
    add_item(CMD_POLL, XFER_FINAL, 8'h00, 0, 0);
    add_item(CMD_POLL, BUSY_BIT, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h00, 8'h00, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait_idle();

    // A zero reset timeout makes the first poll time out.
    write_timeout(16'd0);
    add_item(CMD_RESET, 8'h00, 8'h00, 0, 0);
    add_item(CMD_POLL, 8'h01, 8'h00, 0, 0);
    wait_idle();

    write_timeout(16'd1);
    gen_random(PHASE_ITEMS);
    wait_idle();
    write_timeout(16'hffff);
    gen_random(PHASE_ITEMS);
    wait_idle();
    write_timeout(16'($urandom_range(20, 400)));
    gen_random(PHASE_ITEMS);
    wait_idle();
    write_timeout(RESET_TIMEOUT_INIT);
    gen_random(PHASE_ITEMS);
    wait_idle();
    write_timeout(16'($urandom_range(1, 65535)));
    gen_random(PHASE_ITEMS);
    wait_idle();
    write_timeout(16'hffff);
    gen_overflow();
    wait_idle();

    repeat (10) @(posedge clk);
    n_bad += host_results_q.size();
    $display("Covered %0d items and %0d results: %0d register writes, %0d reply bytes, %0d status bytes.",
             n_in_acc, n_results, n_writes, n_replies, n_status);
    $display("Outcomes: %0d timeouts, %0d errors, %0d rejections over %0d reset_timeout settings.",
             n_timeouts, n_errors, n_rejected, n_settings);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("Failures: %0d", n_bad);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
